[hdl/spq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, constants and status codes for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TAG_BITS_DEF    = 16;

  localparam int PRIO_W = 8;
  localparam int AGE_W  = 7;
  localparam int CODE_W = 8;
  localparam int TAG_W  = 16;
  localparam int FILL_W = 5;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_PLACE,
    S_POP_WAIT,
    S_DONE
  } spq_state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic place;
    logic pop_read;
    logic pop_take;
    logic res_empty;
    logic res_full;
  } spq_cmd_t;

  typedef struct packed {
    logic is_insert;
    logic is_full;
    logic is_empty;
    logic shift_needed;
    logic pos_is_one;
  } spq_stat_t;

endpackage

[hdl/spq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/spq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer for insert scan/shift and pop; issues datapath commands.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  spq_pkg::spq_stat_t st,
  output spq_pkg::spq_cmd_t  cmd,
  output logic               busy,
  output logic               done
);

  spq_pkg::spq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      spq_pkg::S_IDLE: begin
        if (start) state_next = spq_pkg::S_DECIDE;
      end
      spq_pkg::S_DECIDE: begin
        if (st.is_insert) begin
          if (st.is_full || st.is_empty) state_next = spq_pkg::S_DONE;
          else state_next = spq_pkg::S_SCAN;
        end else begin
          if (st.is_empty) state_next = spq_pkg::S_DONE;
          else state_next = spq_pkg::S_POP_WAIT;
        end
      end
      spq_pkg::S_SCAN: begin
        if (st.shift_needed) begin
          if (st.pos_is_one) state_next = spq_pkg::S_PLACE;
        end else begin
          state_next = spq_pkg::S_DONE;
        end
      end
      spq_pkg::S_PLACE:    state_next = spq_pkg::S_DONE;
      spq_pkg::S_POP_WAIT: state_next = spq_pkg::S_DONE;
      spq_pkg::S_DONE:     state_next = spq_pkg::S_IDLE;
      default:             state_next = spq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != spq_pkg::S_IDLE);
    done = (state == spq_pkg::S_DONE);
    case (state)
      spq_pkg::S_IDLE: begin
        cmd.load = start;
      end
      spq_pkg::S_DECIDE: begin
        if (st.is_insert) begin
          if (st.is_full) cmd.res_full = 1'b1;
          else if (st.is_empty) cmd.place = 1'b1;
          else cmd.scan_start = 1'b1;
        end else begin
          if (st.is_empty) cmd.res_empty = 1'b1;
          else cmd.pop_read = 1'b1;
        end
      end
      spq_pkg::S_SCAN: begin
        if (st.shift_needed) cmd.scan_step = 1'b1;
        else cmd.place = 1'b1;
      end
      spq_pkg::S_PLACE:    cmd.place = 1'b1;
      spq_pkg::S_POP_WAIT: cmd.pop_take = 1'b1;
      default: ;
    endcase
  end

endmodule

[hdl/spq_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_datapath
// Circular sorted store in RAM, head/count/position registers, result regs.
// ----------------------------------------------------------------------------
module spq_datapath #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = spq_pkg::TAG_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  spq_pkg::spq_cmd_t                cmd,
  output spq_pkg::spq_stat_t               st,
  input  logic                             mode,
  input  logic [spq_pkg::PRIO_W-1:0]       priority_req,
  input  logic [spq_pkg::AGE_W-1:0]        age,
  input  logic [spq_pkg::CODE_W-1:0]       case_code,
  input  logic [spq_pkg::TAG_W-1:0]        record_tag,
  output logic [spq_pkg::STAT_W-1:0]       status,
  output logic [spq_pkg::PRIO_W-1:0]       out_priority,
  output logic [spq_pkg::AGE_W-1:0]        out_age,
  output logic [spq_pkg::CODE_W-1:0]       out_case_code,
  output logic [spq_pkg::TAG_W-1:0]        out_tag,
  output logic [spq_pkg::FILL_W-1:0]       fill_count
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = spq_pkg::PRIO_W + spq_pkg::AGE_W + spq_pkg::CODE_W + TAG_BITS;
  localparam logic [AW:0]   DEPTH_X = (AW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(QUEUE_DEPTH - 1);

  logic                        mode_r;
  logic [spq_pkg::PRIO_W-1:0]  prio_r;
  logic [spq_pkg::AGE_W-1:0]   age_r;
  logic [spq_pkg::CODE_W-1:0]  code_r;
  logic [TAG_BITS-1:0]         tag_r;
  logic [AW-1:0]               head;
  logic [AW-1:0]               pos;
  logic [CW-1:0]               count;

  logic [31:0]                 tag_in_ext;
  logic [31:0]                 tag_out_ext;
  logic [EW-1:0]               new_entry;
  logic [EW-1:0]               rdata;
  logic [spq_pkg::PRIO_W-1:0]  rd_prio;
  logic [spq_pkg::AGE_W-1:0]   rd_age;
  logic [spq_pkg::CODE_W-1:0]  rd_code;
  logic [TAG_BITS-1:0]         rd_tag;

  logic [AW-1:0]               rd_log;
  logic [AW:0]                 rd_sum;
  logic [AW-1:0]               raddr;
  logic [AW:0]                 wr_sum;
  logic [AW-1:0]               waddr;
  logic                        we;
  logic                        re;
  logic [EW-1:0]               wdata;
  logic [31:0]                 count_ext;

  assign tag_in_ext = {16'b0, record_tag};
  assign new_entry  = {prio_r, age_r, code_r, tag_r};
  assign {rd_prio, rd_age, rd_code, rd_tag} = rdata;
  assign tag_out_ext = 32'(rd_tag);

  assign st.is_insert    = ~mode_r;
  assign st.is_full      = (count >= DEPTH_C);
  assign st.is_empty     = (count == '0);
  assign st.shift_needed = (rd_prio > prio_r);
  assign st.pos_is_one   = (pos == AW'(1));

  // read address: logical slot relative to head, wrapped
  always_comb begin
    rd_log = '0;
    if (cmd.scan_start) rd_log = pos - AW'(1);
    else if (cmd.scan_step) rd_log = pos - AW'(2);
    rd_sum = {1'b0, head} + {1'b0, rd_log};
    if (rd_sum >= DEPTH_X) rd_sum = rd_sum - DEPTH_X;
    raddr = rd_sum[AW-1:0];
    re    = cmd.scan_start | cmd.pop_read | (cmd.scan_step & ~st.pos_is_one);
  end

  always_comb begin
    wr_sum = {1'b0, head} + {1'b0, pos};
    if (wr_sum >= DEPTH_X) wr_sum = wr_sum - DEPTH_X;
    waddr = wr_sum[AW-1:0];
    we    = cmd.scan_step | cmd.place;
    wdata = cmd.scan_step ? rdata : new_entry;
  end

  spq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (cmd.place) count <= count + CW'(1);
      if (cmd.pop_take) begin
        count <= count - CW'(1);
        head  <= (head == LAST_A) ? '0 : head + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode;
      prio_r <= priority_req;
      age_r  <= age;
      code_r <= case_code;
      tag_r  <= tag_in_ext[TAG_BITS-1:0];
      pos    <= AW'(count);
    end
    if (cmd.scan_step) pos <= pos - AW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.place || cmd.res_empty || cmd.res_full) begin
      status        <= cmd.res_empty ? spq_pkg::STATUS_EMPTY :
                       cmd.res_full  ? spq_pkg::STATUS_FULL  : spq_pkg::STATUS_OK;
      out_priority  <= '0;
      out_age       <= '0;
      out_case_code <= '0;
      out_tag       <= '0;
    end else if (cmd.pop_take) begin
      status        <= spq_pkg::STATUS_OK;
      out_priority  <= rd_prio;
      out_age       <= rd_age;
      out_case_code <= rd_code;
      out_tag       <= tag_out_ext[spq_pkg::TAG_W-1:0];
    end
  end

  assign count_ext  = 32'(count);
  assign fill_count = (count_ext > 32'd31) ? 5'd31 : count_ext[spq_pkg::FILL_W-1:0];

endmodule

[hdl/stable_priority_queue_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_core
// Bounded stable min-priority queue: sorted insert with shift, pop from head.
// ----------------------------------------------------------------------------
// Pop reads the head entry, then takes it. Insert shifts each held entry of larger
//   priority value (one RAM read/write each), then places; into empty, at once.
// Throughput: one beat at a time; next start taken the cycle after done.
// Result is shown for one cycle on done; the receiver cannot stall.
// Reset (rst, synchronous): queue empty, controller idle; RAM contents unused.
module stable_priority_queue_core #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = spq_pkg::TAG_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       mode,
  input  logic [spq_pkg::PRIO_W-1:0] priority_req,
  input  logic [spq_pkg::AGE_W-1:0]  age,
  input  logic [spq_pkg::CODE_W-1:0] case_code,
  input  logic [spq_pkg::TAG_W-1:0]  record_tag,
  output logic                       done,
  output logic [spq_pkg::STAT_W-1:0] status,
  output logic [spq_pkg::PRIO_W-1:0] out_priority,
  output logic [spq_pkg::AGE_W-1:0]  out_age,
  output logic [spq_pkg::CODE_W-1:0] out_case_code,
  output logic [spq_pkg::TAG_W-1:0]  out_tag,
  output logic [spq_pkg::FILL_W-1:0] fill_count
);

  spq_pkg::spq_cmd_t  cmd;
  spq_pkg::spq_stat_t st;

  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .mode          (mode),
    .priority_req  (priority_req),
    .age           (age),
    .case_code     (case_code),
    .record_tag    (record_tag),
    .status        (status),
    .out_priority  (out_priority),
    .out_age       (out_age),
    .out_case_code (out_case_code),
    .out_tag       (out_tag),
    .fill_count    (fill_count)
  );

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted beat did not start work");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");
  a_nopop_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != spq_pkg::STATUS_OK |->
    out_priority == '0 && out_age == '0 && out_case_code == '0 && out_tag == '0)
    else $error("error result carries record data");
`endif

endmodule

[dv/stable_priority_queue_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_core_tb
// Self-checking bench for the stable min-priority queue. Drives insert and pop
// beats through the start/busy handshake. Each accepted beat updates a local
// sorted model of the queue, which yields the expected result. Every done
// strobe is checked field by field against the oldest pending expectation.
// ----------------------------------------------------------------------------
module stable_priority_queue_core_tb;

  localparam int DEPTH       = spq_pkg::QUEUE_DEPTH_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_POP    = 1'b1;

  typedef struct packed {
    logic [spq_pkg::PRIO_W-1:0] prio;
    logic [spq_pkg::AGE_W-1:0]  age;
    logic [spq_pkg::CODE_W-1:0] code;
    logic [spq_pkg::TAG_W-1:0]  tag;
  } record_t;

  typedef struct packed {
    logic [spq_pkg::STAT_W-1:0] status;
    record_t                    rec;
    logic [spq_pkg::FILL_W-1:0] fill;
  } pq_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       mode = MODE_INSERT;
  logic [spq_pkg::PRIO_W-1:0] priority_req = '0;
  logic [spq_pkg::AGE_W-1:0]  age = '0;
  logic [spq_pkg::CODE_W-1:0] case_code = '0;
  logic [spq_pkg::TAG_W-1:0]  record_tag = '0;
  logic                       busy;
  logic                       done;
  logic [spq_pkg::STAT_W-1:0] status;
  logic [spq_pkg::PRIO_W-1:0] out_priority;
  logic [spq_pkg::AGE_W-1:0]  out_age;
  logic [spq_pkg::CODE_W-1:0] out_case_code;
  logic [spq_pkg::TAG_W-1:0]  out_tag;
  logic [spq_pkg::FILL_W-1:0] fill_count;

  record_t    held_records[$];
  pq_result_t pending_results[$];
  int         error_count = 0;
  int         stall_cycles = 0;

  stable_priority_queue_core u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .priority_req (priority_req),
    .age          (age),
    .case_code    (case_code),
    .record_tag   (record_tag),
    .done         (done),
    .status       (status),
    .out_priority (out_priority),
    .out_age      (out_age),
    .out_case_code(out_case_code),
    .out_tag      (out_tag),
    .fill_count   (fill_count)
  );

  always #5 clk = ~clk;

  function automatic pq_result_t queue_step(logic m, record_t rec);
    pq_result_t r;
    int pos;
    r = '0;
    if (m == MODE_INSERT) begin
      if (held_records.size() >= DEPTH) begin
        r.status = spq_pkg::STATUS_FULL;
      end else begin
        pos = held_records.size();
        while (pos > 0 && held_records[pos-1].prio > rec.prio) pos--;
        held_records.insert(pos, rec);
        r.status = spq_pkg::STATUS_OK;
      end
    end else begin
      if (held_records.size() == 0) begin
        r.status = spq_pkg::STATUS_EMPTY;
      end else begin
        r.rec = held_records.pop_front();
        r.status = spq_pkg::STATUS_OK;
      end
    end
    r.fill = (held_records.size() > 31) ? 5'd31 :
             spq_pkg::FILL_W'(held_records.size());
    return r;
  endfunction

  task automatic idle_cycle();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // busy only moves on rising edges, so its value at the falling edge
  // tells whether the coming edge takes the beat
  task automatic send_beat(logic m, logic [spq_pkg::PRIO_W-1:0] p,
                           logic [spq_pkg::AGE_W-1:0] a,
                           logic [spq_pkg::CODE_W-1:0] c,
                           logic [spq_pkg::TAG_W-1:0] t);
    record_t rec;
    @(negedge clk);
    start        <= 1'b1;
    mode         <= m;
    priority_req <= p;
    age          <= a;
    case_code    <= c;
    record_tag   <= t;
    while (busy) @(negedge clk);
    @(posedge clk);
    rec = '{prio: p, age: a, code: c, tag: t};
    pending_results.push_back(queue_step(m, rec));
  endtask

  task automatic drain_results();
    idle_cycle();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    pq_result_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no pending expectation");
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status", 32'(exp_r.status), 32'(status));
        check_field("out_priority", 32'(exp_r.rec.prio), 32'(out_priority));
        check_field("out_age", 32'(exp_r.rec.age), 32'(out_age));
        check_field("out_case_code", 32'(exp_r.rec.code), 32'(out_case_code));
        check_field("out_tag", 32'(exp_r.rec.tag), 32'(out_tag));
        check_field("fill_count", 32'(exp_r.fill), 32'(fill_count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic test_pop_empty();
    send_beat(MODE_POP, 8'hFF, 7'h7F, 8'hFF, 16'hFFFF);
    drain_results();
  endtask

  // ties, extremes and a dropped insert once full
  task automatic test_fill_to_full();
    send_beat(MODE_INSERT, 8'd100, 7'd0,   8'd0,   16'h0000);
    send_beat(MODE_INSERT, 8'd255, 7'd127, 8'd255, 16'hFFFF);
    send_beat(MODE_INSERT, 8'd0,   7'd1,   8'd1,   16'h0001);
    send_beat(MODE_INSERT, 8'd100, 7'd2,   8'd2,   16'h0002);
    send_beat(MODE_INSERT, 8'd0,   7'd3,   8'd3,   16'h8000);
    send_beat(MODE_INSERT, 8'd255, 7'd4,   8'd4,   16'h0004);
    send_beat(MODE_INSERT, 8'd50,  7'd64,  8'd128, 16'h5555);
    send_beat(MODE_INSERT, 8'd100, 7'd5,   8'd5,   16'hAAAA);
    send_beat(MODE_INSERT, 8'd1,   7'd6,   8'd6,   16'h0006);
    send_beat(MODE_INSERT, 8'd254, 7'd7,   8'd7,   16'h0007);
    send_beat(MODE_INSERT, 8'd0,   7'd8,   8'd8,   16'h0008);
    send_beat(MODE_INSERT, 8'd128, 7'd9,   8'd9,   16'h0009);
    send_beat(MODE_INSERT, 8'd127, 7'd10,  8'd10,  16'h000A);
    send_beat(MODE_INSERT, 8'd100, 7'd11,  8'd11,  16'h000B);
    send_beat(MODE_INSERT, 8'd50,  7'd12,  8'd12,  16'h000C);
    send_beat(MODE_INSERT, 8'd255, 7'd13,  8'd13,  16'h000D);
    send_beat(MODE_INSERT, 8'd0,   7'd127, 8'd255, 16'hFFFF);
    drain_results();
  endtask

  task automatic test_stable_pop();
    repeat (6) send_beat(MODE_POP, spq_pkg::PRIO_W'($urandom_range(255)),
                         spq_pkg::AGE_W'($urandom_range(127)),
                         spq_pkg::CODE_W'($urandom_range(255)),
                         spq_pkg::TAG_W'($urandom_range(65535)));
    drain_results();
  endtask

  task automatic test_random(int n_items, int gap_pct);
    logic                       m;
    logic [spq_pkg::PRIO_W-1:0] p;
    int                         pop_pct;
    int                         stretch;
    stretch = 0;
    pop_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      if (stretch == 0) begin
        pop_pct = $urandom_range(1) ? 25 : 75;
        stretch = $urandom_range(40, 4);
      end
      stretch--;
      m = ($urandom_range(99) < pop_pct) ? MODE_POP : MODE_INSERT;
      case ($urandom_range(2))
        0: p = spq_pkg::PRIO_W'($urandom_range(255));
        1: p = spq_pkg::PRIO_W'($urandom_range(3));
        default: p = spq_pkg::PRIO_W'($urandom_range(255, 252));
      endcase
      while ($urandom_range(99) < gap_pct) idle_cycle();
      send_beat(m, p, spq_pkg::AGE_W'($urandom_range(127)),
                spq_pkg::CODE_W'($urandom_range(255)),
                spq_pkg::TAG_W'($urandom_range(65535)));
      if ($urandom_range(99) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_pop_empty();
    test_fill_to_full();
    test_stable_pop();
    test_random(420, 29);
    test_random(420, 87);
    test_random(410, 0);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
